// File: rtl/core/cpu_clock_step_breakpoint_controller_macros.svh
// Assertion macros shared by the clock step controller RTL.
`ifndef CPU_CLOCK_STEP_BREAKPOINT_CONTROLLER_MACROS_SVH
`define CPU_CLOCK_STEP_BREAKPOINT_CONTROLLER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define CCSB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define CCSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/ccsb_pkg.sv
// Package: types and constants of the clock step controller.
`timescale 1ns / 1ps
package ccsb_pkg;

	// Bit positions of the active-low control lines
	localparam int unsigned CE_ROM_BIT = 0;
	localparam int unsigned OE_BIT     = 1;

	localparam int unsigned PADDR_W = 4;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_START = 2'd1,
		MODE_STOP  = 2'd2,
		MODE_STEP  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_BP_ADDR = 2'd0,
		REG_BP_EN   = 2'd1,
		REG_MON_OFF = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		PH_LOW_EDGE  = 4'b0001,
		PH_LOW_HOLD  = 4'b0010,
		PH_HIGH_EDGE = 4'b0100,
		PH_HIGH_HOLD = 4'b1000
	} phase_t;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] address;
		logic [7:0]  control;
		logic [7:0]  data_bus;
	} cmd_item_t;

	typedef struct packed {
		logic        clock_level;
		logic [1:0]  clock_phase;
		logic        drive_rom_data;
		logic        is_running;
		logic [1:0]  monitor_count;
		logic [7:0]  monitor_control;
		logic [15:0] monitor_address;
		logic [7:0]  monitor_data;
		logic        breakpoint_hit;
	} res_item_t;

	typedef struct packed {
		logic [15:0] bp_address;
		logic        bp_enable;
		logic        monitor_off;
	} cfg_t;

	typedef struct packed {
		phase_t phase;
		logic   clock_out;
		logic   rom_driving;
		logic   running;
		logic   run_requested;
		logic   step_pending;
		logic   ticking;
	} ctl_state_t;

	// Map the one-hot phase onto its numeric code
	function automatic logic [1:0] phase_code(input phase_t ph);
		logic [1:0] code;
		case (ph)
			PH_LOW_EDGE:  code = 2'd0;
			PH_LOW_HOLD:  code = 2'd1;
			PH_HIGH_EDGE: code = 2'd2;
			PH_HIGH_HOLD: code = 2'd3;
			default:      code = 2'd0;
		endcase
		return code;
	endfunction

endpackage

// File: rtl/core/ccsb_if.sv
// Interfaces: command and result channels of the clock step controller.
`timescale 1ns / 1ps
interface ccsb_cmd_if;
	import ccsb_pkg::*;
	logic      valid;
	logic      ready;
	cmd_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ccsb_res_if;
	import ccsb_pkg::*;
	logic      valid;
	logic      ready;
	res_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/ccsb_step.sv
// Module: next-state and result logic for one command or clock tick.
`timescale 1ns / 1ps
module ccsb_step (
	input  ccsb_pkg::cfg_t       cfg,
	input  ccsb_pkg::ctl_state_t st,
	input  ccsb_pkg::cmd_item_t  item,
	output ccsb_pkg::ctl_state_t st_next,
	output ccsb_pkg::res_item_t  res
);
	import ccsb_pkg::*;

	logic [1:0] count;
	logic       hit;
	logic       rom_select;
	logic       bp_match;

	assign rom_select = !item.control[CE_ROM_BIT] && !item.control[OE_BIT];
	assign bp_match   = cfg.bp_enable && (item.address == cfg.bp_address);

	// Advance the clock phase or apply a command
	always_comb begin
		st_next = st;
		count   = 2'd0;
		hit     = 1'b0;
		case (item.mode)
			MODE_TICK: begin
				if (st.ticking) begin
					case (st.phase)
						PH_LOW_EDGE: begin
							st_next.clock_out   = 1'b0;
							st_next.rom_driving = 1'b0;
							if (!st.run_requested) begin
								st_next.ticking = 1'b0;
								st_next.running = 1'b0;
							end else if (st.running && st.step_pending) begin
								// single step done: the stepped clock period is complete, so halt
								st_next.ticking      = 1'b0;
								st_next.running      = 1'b0;
								st_next.step_pending = 1'b0;
							end else begin
								st_next.running = 1'b1;
								st_next.phase   = PH_LOW_HOLD;
							end
						end
						PH_LOW_HOLD: begin
							st_next.phase = PH_HIGH_EDGE;
						end
						PH_HIGH_EDGE: begin
							st_next.clock_out = 1'b1;
							if (rom_select) begin
								st_next.rom_driving = 1'b1;
							end
							st_next.phase = PH_HIGH_HOLD;
						end
						PH_HIGH_HOLD: begin
							if (!cfg.monitor_off || st.step_pending) begin
								count = count + 2'd1;
							end
							if (bp_match) begin
								if (cfg.monitor_off) begin
									count = count + 2'd1;
								end
								st_next.run_requested = 1'b0;
								hit = 1'b1;
							end
							st_next.phase = PH_LOW_EDGE;
						end
						default: begin
							st_next.phase = PH_LOW_EDGE;
						end
					endcase
				end
			end
			MODE_START: begin
				st_next.run_requested = 1'b1;
				st_next.ticking       = 1'b1;
			end
			MODE_STOP: begin
				st_next.run_requested = 1'b0;
			end
			MODE_STEP: begin
				st_next.running       = 1'b0;
				st_next.step_pending  = 1'b1;
				st_next.run_requested = 1'b1;
				st_next.ticking       = 1'b1;
			end
			default: begin
				st_next = st;
			end
		endcase
	end

	// Build the result beat; zero the record when none is reported
	always_comb begin
		res.clock_level     = st_next.clock_out;
		res.clock_phase     = phase_code(st_next.phase);
		res.drive_rom_data  = st_next.rom_driving;
		res.is_running      = st_next.running;
		res.monitor_count   = count;
		res.monitor_control = (count != 2'd0) ? item.control  : 8'd0;
		res.monitor_address = (count != 2'd0) ? item.address  : 16'd0;
		res.monitor_data    = (count != 2'd0) ? item.data_bus : 8'd0;
		res.breakpoint_hit  = hit;
	end

endmodule

// File: rtl/core/cpu_clock_step_breakpoint_controller.sv
// Top level: debug clock step controller with breakpoint and bus monitor.
//
// Usage: the cmd channel takes one beat per clock tick or command (mode 0
// tick, 1 start, 2 stop, 3 single step) together with the sampled address,
// control lines and data byte. The res channel returns one beat for every
// cmd beat, in order: CPU clock level, phase, ROM drive enable, run state,
// monitor record count and fields, and the breakpoint hit flag.
// Registers (breakpoint address, breakpoint enable, monitor off) sit on the
// APB port at byte addresses 0, 4 and 8; write them only while no beat is
// in flight.
// Path: a cmd beat sits in the input register, its result in the result
// register that drives res. Throughput: one beat per cycle while res is
// taken, set by the single input and result registers of the step logic.
// Reset: all control state and registers clear; the clock line is low,
// the CPU halted and ticking disabled.
// Stall: when res is not taken, the result register holds and the input
// register fills; cmd.ready drops once both are full.
`timescale 1ns / 1ps
`include "cpu_clock_step_breakpoint_controller_macros.svh"
module cpu_clock_step_breakpoint_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	ccsb_cmd_if.sink                      cmd,
	ccsb_res_if.source                    res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ccsb_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import ccsb_pkg::*;

	cfg_t       cfg_q;
	ctl_state_t state_q;
	ctl_state_t state_next;
	cmd_item_t  item_s1;
	logic       valid_s1;
	res_item_t  res_s2;
	res_item_t  res_next;
	logic       valid_s2;
	logic       advance;
	logic       cfg_write;
	cfg_reg_t   reg_sel;

	// Register port
	assign pready    = 1'b1;
	assign reg_sel   = cfg_reg_t'(paddr[3:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (reg_sel)
				REG_BP_ADDR: cfg_q.bp_address  <= pwdata[15:0];
				REG_BP_EN:   cfg_q.bp_enable   <= pwdata[0];
				REG_MON_OFF: cfg_q.monitor_off <= pwdata[0];
				default:     cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_BP_ADDR: prdata = {16'd0, cfg_q.bp_address};
			REG_BP_EN:   prdata = {31'd0, cfg_q.bp_enable};
			REG_MON_OFF: prdata = {31'd0, cfg_q.monitor_off};
			default:     prdata = 32'd0;
		endcase
	end

	// Move a beat from the input register into the result register
	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= cmd.data;
		end
	end

	ccsb_step u_step (
		.cfg     (cfg_q),
		.st      (state_q),
		.item    (item_s1),
		.st_next (state_next),
		.res     (res_next)
	);

	// Commit controller state with each beat that advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase         <= PH_LOW_EDGE;
			state_q.clock_out     <= 1'b0;
			state_q.rom_driving   <= 1'b0;
			state_q.running       <= 1'b0;
			state_q.run_requested <= 1'b0;
			state_q.step_pending  <= 1'b0;
			state_q.ticking       <= 1'b0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign res.valid = valid_s2;
	assign res.data  = res_s2;

	// Checks
	`CCSB_ASSERT_SAME(a_phase_onehot, clk, arst_n, 1'b1, $onehot(state_q.phase),
		"phase register lost its one-hot code")
	`CCSB_ASSERT_SAME(a_idle_at_low_edge, clk, arst_n, !state_q.ticking,
		state_q.phase == PH_LOW_EDGE, "ticking stopped away from the low edge")
	`CCSB_ASSERT_SAME(a_hit_ends_cycle, clk, arst_n, valid_s2 && res_s2.breakpoint_hit,
		(res_s2.clock_phase == 2'd0) && (res_s2.monitor_count != 2'd0),
		"breakpoint hit without a record or outside the high hold")
	`CCSB_ASSERT_NEXT(a_stop_on_hit, clk, arst_n, advance && res_next.breakpoint_hit,
		!state_q.run_requested, "breakpoint hit left the run request set")

endmodule

// File: verif/cpu_clock_step_breakpoint_controller_checker.sv
`timescale 1ns / 1ps
// Checker: predicts each result beat of the clock step controller and compares it.
module cpu_clock_step_breakpoint_controller_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	input  logic                         cmd_ready,
	input  ccsb_pkg::cmd_item_t          cmd_data,
	input  logic                         res_valid,
	input  logic                         res_ready,
	input  ccsb_pkg::res_item_t          res_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [ccsb_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	input  logic [31:0]                  prdata,
	output int                           failures,
	output int                           pending,
	output int                           records,
	output int                           breakpoint_hits
);
	import ccsb_pkg::*;

	typedef enum logic [1:0] {
		LOW_EDGE  = 2'd0,
		LOW_HOLD  = 2'd1,
		HIGH_EDGE = 2'd2,
		HIGH_HOLD = 2'd3
	} clock_phase_t;

	// Register copy
	logic [15:0] bp_address;
	logic        bp_enable;
	logic        monitor_off;

	// Controller state copy
	clock_phase_t phase;
	logic         clock_out;
	logic         rom_driving;
	logic         running;
	logic         run_requested;
	logic         step_pending;
	logic         ticking;

	res_item_t expected_results[$];

	// Advance the controller by one beat and build its result
	function automatic res_item_t step_cpu_clock(input cmd_item_t beat);
		res_item_t  r;
		logic [1:0] count;
		logic       hit;
		count = '0;
		hit = 1'b0;
		r = '0;
		case (beat.mode)
			MODE_TICK: begin
				if (ticking) begin
					case (phase)
						LOW_EDGE: begin
							clock_out = 1'b0;
							rom_driving = 1'b0;
							if (!run_requested) begin
								ticking = 1'b0;
								running = 1'b0;
							end else if (running && step_pending) begin
								// single step done: halt and stop ticking
								ticking = 1'b0;
								running = 1'b0;
								step_pending = 1'b0;
							end else begin
								running = 1'b1;
								phase = LOW_HOLD;
							end
						end
						LOW_HOLD: phase = HIGH_EDGE;
						HIGH_EDGE: begin
							clock_out = 1'b1;
							if (!beat.control[CE_ROM_BIT] && !beat.control[OE_BIT])
								rom_driving = 1'b1;
							phase = HIGH_HOLD;
						end
						default: begin
							if (!monitor_off || step_pending)
								count = count + 2'd1;
							if (bp_enable && beat.address == bp_address) begin
								if (monitor_off)
									count = count + 2'd1;
								run_requested = 1'b0;
								hit = 1'b1;
							end
							phase = LOW_EDGE;
						end
					endcase
				end
			end
			MODE_START: begin
				run_requested = 1'b1;
				ticking = 1'b1;
			end
			MODE_STOP: run_requested = 1'b0;
			default: begin
				running = 1'b0;
				step_pending = 1'b1;
				run_requested = 1'b1;
				ticking = 1'b1;
			end
		endcase
		r.clock_level = clock_out;
		r.clock_phase = phase;
		r.drive_rom_data = rom_driving;
		r.is_running = running;
		r.monitor_count = count;
		r.breakpoint_hit = hit;
		if (count != 2'd0) begin
			r.monitor_control = beat.control;
			r.monitor_address = beat.address;
			r.monitor_data = beat.data_bus;
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp,
			input logic [31:0] act);
		if (exp !== act) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
			failures++;
		end
	endfunction

	function automatic void compare_result(input res_item_t exp, input res_item_t act);
		check_field("clock_level", exp.clock_level, act.clock_level);
		check_field("clock_phase", exp.clock_phase, act.clock_phase);
		check_field("drive_rom_data", exp.drive_rom_data, act.drive_rom_data);
		check_field("is_running", exp.is_running, act.is_running);
		check_field("monitor_count", exp.monitor_count, act.monitor_count);
		check_field("monitor_control", exp.monitor_control, act.monitor_control);
		check_field("monitor_address", exp.monitor_address, act.monitor_address);
		check_field("monitor_data", exp.monitor_data, act.monitor_data);
		check_field("breakpoint_hit", exp.breakpoint_hit, act.breakpoint_hit);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_item_t exp;
		if (!arst_n) begin
			bp_address = '0;
			bp_enable = 1'b0;
			monitor_off = 1'b0;
			phase = LOW_EDGE;
			clock_out = 1'b0;
			rom_driving = 1'b0;
			running = 1'b0;
			run_requested = 1'b0;
			step_pending = 1'b0;
			ticking = 1'b0;
			expected_results.delete();
			failures = 0;
			pending = 0;
			records = 0;
			breakpoint_hits = 0;
		end else begin
			// track register writes; unmapped indexes are dropped
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_BP_ADDR: bp_address = pwdata[15:0];
					REG_BP_EN:   bp_enable = pwdata[0];
					REG_MON_OFF: monitor_off = pwdata[0];
					default: ;
				endcase
			end
			// check register reads
			if (psel && penable && !pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_BP_ADDR: check_field("breakpoint_address", {16'd0, bp_address}, prdata);
					REG_BP_EN:   check_field("breakpoint_enable", {31'd0, bp_enable}, prdata);
					REG_MON_OFF: check_field("monitor_off", {31'd0, monitor_off}, prdata);
					default: ;
				endcase
			end
			// compare the result beat with the oldest expectation
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no command beat outstanding");
					failures++;
				end else begin
					exp = expected_results.pop_front();
					compare_result(exp, res_data);
					records += exp.monitor_count;
					breakpoint_hits += exp.breakpoint_hit;
				end
			end
			// predict the accepted command beat
			if (cmd_valid && cmd_ready)
				expected_results.push_back(step_cpu_clock(cmd_data));
			pending = expected_results.size();
		end
	end

endmodule

// File: verif/cpu_clock_step_breakpoint_controller_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives commands and registers of the clock step controller.
module cpu_clock_step_breakpoint_controller_tb;
	import ccsb_pkg::*;

	localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = {2'd3, 2'b00};
	localparam int RANDOM_PHASES = 6;
	localparam int BEATS_PER_PHASE = 175;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	int          failures;
	int          pending;
	int          records;
	int          breakpoint_hits;
	int          beats_sent;
	int          settings_used;
	logic        quiet;
	logic [15:0] bp_target;

	ccsb_cmd_if cmd_ch ();
	ccsb_res_if res_ch ();

	cpu_clock_step_breakpoint_controller i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	cpu_clock_step_breakpoint_controller_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_ch.valid),
		.cmd_ready       (cmd_ch.ready),
		.cmd_data        (cmd_ch.data),
		.res_valid       (res_ch.valid),
		.res_ready       (res_ch.ready),
		.res_data        (res_ch.data),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.failures        (failures),
		.pending         (pending),
		.records         (records),
		.breakpoint_hits (breakpoint_hits)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the handshakes hang
	initial begin
		#2ms;
		$display("TEST FAILED");
		$finish;
	end

	// Stall the result channel in random bursts
	initial begin
		res_ch.ready = 1'b1;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
		end
	end

	// Send one command beat, with an optional gap in front
	task automatic send_beat(input cmd_item_t beat);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= beat;
		do @(posedge clk); while (!cmd_ch.ready);
		@(negedge clk);
		beats_sent++;
	endtask

	task automatic send_cmd(input mode_t mode, input logic [15:0] address,
			input logic [7:0] control, input logic [7:0] data_bus);
		cmd_item_t beat;
		beat.mode = mode;
		beat.address = address;
		beat.control = control;
		beat.data_bus = data_bus;
		send_beat(beat);
	endtask

	// Run one full clock cycle: low edge, low hold, high edge, high hold
	task automatic send_cycle(input logic [7:0] edge_control, input logic [15:0] hold_address);
		send_cmd(MODE_TICK, 16'h0000, 8'hFF, 8'h00);
		send_cmd(MODE_TICK, 16'hFFFF, 8'h00, 8'hFF);
		send_cmd(MODE_TICK, 16'h5A5A, edge_control, 8'h3C);
		send_cmd(MODE_TICK, hold_address, 8'hA5, 8'hC3);
	endtask

	// Setup and access cycle, then idle before the next access
	task automatic apb_access(input logic write, input logic [PADDR_W-1:0] addr,
			input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// Program and read back all registers; only called while idle
	task automatic load_settings(input logic [15:0] address, input logic enable,
			input logic mon_off);
		apb_access(1'b1, {REG_BP_ADDR, 2'b00}, {16'hFFFF, address});
		apb_access(1'b1, {REG_BP_EN, 2'b00}, {31'h7FFFFFFF, enable});
		apb_access(1'b1, {REG_MON_OFF, 2'b00}, {31'd0, mon_off});
		apb_access(1'b0, {REG_BP_ADDR, 2'b00}, '0);
		apb_access(1'b0, {REG_BP_EN, 2'b00}, '0);
		apb_access(1'b0, {REG_MON_OFF, 2'b00}, '0);
		bp_target = address;
		settings_used++;
	endtask

	// Drain all outstanding results, then allow the pipeline to settle
	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic cmd_item_t random_beat();
		cmd_item_t beat;
		int        pick;
		pick = $urandom_range(0, 99);
		if (pick < 78)
			beat.mode = MODE_TICK;
		else if (pick < 86)
			beat.mode = MODE_START;
		else if (pick < 91)
			beat.mode = MODE_STOP;
		else
			beat.mode = MODE_STEP;
		beat.address = ($urandom_range(0, 5) == 0) ? bp_target : 16'($urandom);
		beat.control = 8'($urandom);
		beat.data_bus = 8'($urandom);
		return beat;
	endfunction

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		quiet = 1'b0;
		bp_target = '0;
		beats_sent = 0;
		settings_used = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: breakpoint armed, monitor on
		load_settings(16'h1234, 1'b1, 1'b0);
		// write to an unmapped index must leave the breakpoint alone
		apb_access(1'b1, UNMAPPED_ADDR, 32'hFFFFFFFF);
		send_cmd(MODE_TICK, 16'hFFFF, 8'hFF, 8'hFF);
		send_cmd(MODE_STOP, 16'h0000, 8'h00, 8'h00);
		send_cmd(MODE_START, 16'h0000, 8'h00, 8'h00);
		send_cycle(8'h00, 16'h0000);
		send_cycle(8'hFF, 16'h1234);
		// run request cleared by the hit: next low edge halts
		send_cmd(MODE_TICK, 16'h1234, 8'h00, 8'h00);
		send_cmd(MODE_STEP, 16'h0000, 8'h00, 8'h00);
		send_cycle(8'hFC, 16'hFFFF);
		send_cmd(MODE_TICK, 16'h0000, 8'h00, 8'h00);
		wait_idle();

		// directed: monitor off, breakpoint hit alone and during a step
		load_settings(16'hFFFF, 1'b1, 1'b1);
		send_cmd(MODE_START, 16'h0000, 8'h00, 8'h00);
		send_cycle(8'h01, 16'hFFFF);
		send_cmd(MODE_STEP, 16'h0000, 8'h00, 8'h00);
		send_cycle(8'h02, 16'hFFFF);
		send_cmd(MODE_TICK, 16'h0000, 8'h00, 8'h00);
		wait_idle();

		// random phases over several register settings
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: load_settings(16'h0000, 1'b1, 1'b0);
				1: load_settings(16'hFFFF, 1'b0, 1'b1);
				2: load_settings(16'($urandom), 1'b1, 1'b1);
				3: load_settings(16'($urandom), 1'b0, 1'b0);
				4: load_settings(16'($urandom), 1'b1, 1'b0);
				default: load_settings(16'($urandom), 1'b1, 1'b1);
			endcase
			quiet = (p == RANDOM_PHASES - 1);
			send_cmd(MODE_START, 16'($urandom), 8'($urandom), 8'($urandom));
			for (int i = 0; i < BEATS_PER_PHASE; i++)
				send_beat(random_beat());
			wait_idle();
		end

		repeat (8) @(negedge clk);
		$display("Sent %0d command beats under %0d register settings;", beats_sent,
			settings_used);
		$display("checked %0d monitor records and %0d breakpoint hits.", records,
			breakpoint_hits);
		if (failures == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: cpu_clock_step_breakpoint_controller.f
+incdir+rtl/core
rtl/core/ccsb_pkg.sv
rtl/core/ccsb_if.sv
rtl/core/ccsb_step.sv
rtl/core/cpu_clock_step_breakpoint_controller.sv
verif/cpu_clock_step_breakpoint_controller_checker.sv
verif/cpu_clock_step_breakpoint_controller_tb.sv
